@@ hw/rtl/mme_pkg.sv @@
// Shared types, constants and command codes for the matrix multiply engine.
// No dependencies; every other file in hw/rtl imports this package.
package mme_pkg;

    localparam int MAX_DIM_DEF   = 8;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DIM_W         = 4;
    localparam int IDX_W         = 3;
    localparam int DATA_W        = 32;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int SUM_W         = PROD_W + 4;
    localparam int REG_IDX_W     = 2;

    typedef enum logic [1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_X  = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    localparam logic [REG_IDX_W-1:0] REG_ROWS_OF_A    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_INNER_LENGTH = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COLS_OF_X    = 2'd2;

    typedef struct packed {
        cmd_t                      command;
        logic [IDX_W-1:0]          row_index;
        logic [IDX_W-1:0]          col_index;
        logic signed [DATA_W-1:0]  element_value;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]          out_row;
        logic [IDX_W-1:0]          out_col;
        logic signed [DATA_W-1:0]  product_value;
        logic                      saturated;
        logic                      last;
    } out_item_t;

    // Token that walks the cell chain: which product element it carries.
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } tok_t;

    // Store write broadcast to all cells; lane selects the target cell.
    typedef struct packed {
        logic              a_we;
        logic              x_we;
        logic [IDX_W-1:0]  lane;
        logic [IDX_W-1:0]  entry;
        logic [DATA_W-1:0] data;
    } wr_t;

endpackage

@@ hw/rtl/matrix_multiply_engine_unit.sv @@
// Matrix multiply engine top level: B = A * X over a chain of MAX_DIM cells.
// Each token passes from the sequencer through the token registers of every cell to
// the output register. One result beat and one new token per cycle while the chain
// advances, effective rows_of_a * cols_of_x beats per compute; in_stall holds input
// from an accepted compute until its last result beat is taken; a load causes no stall.
// Reset clears control and sets each dimension register to 1; stores undefined.
module matrix_multiply_engine_unit
    import mme_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    // Configuration registers, written at any time the port offers a beat.
    logic [DIM_W-1:0] rows_reg, inner_reg, cols_reg;
    logic [DIM_W-1:0] dim_m, dim_n, dim_p;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= DIM_W'(1);
            inner_reg <= DIM_W'(1);
            cols_reg  <= DIM_W'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ROWS_OF_A:    rows_reg  <= cfg_data;
                REG_INNER_LENGTH: inner_reg <= cfg_data;
                REG_COLS_OF_X:    cols_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // A zero dimension acts as 1 and one above MAX_DIM acts as MAX_DIM.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

    assign dim_m = eff_dim(rows_reg);
    assign dim_n = eff_dim(inner_reg);
    assign dim_p = eff_dim(cols_reg);

    // The whole chain moves one step whenever the output register can take a beat.
    logic out_valid_reg;
    out_item_t out_item_reg;
    logic advance;

    assign advance = !out_valid_reg || !out_stall;

    // Input beats are taken only while no compute is in flight, so loads never
    // disturb a product being formed.
    logic busy_reg;
    logic in_acc;

    assign in_stall = busy_reg;
    assign in_acc   = in_valid && !busy_reg;

    // Loads: A(r,c) lives in cell c at entry r, X(r,c) in cell r at entry c.
    wr_t wr;
    logic [DIM_W-1:0] r_ext, c_ext;

    assign r_ext = {1'b0, in_item.row_index};
    assign c_ext = {1'b0, in_item.col_index};

    always_comb
    begin
        wr.a_we  = in_acc && (in_item.command == CMD_LOAD_A) &&
                   (r_ext < dim_m) && (c_ext < dim_n);
        wr.x_we  = in_acc && (in_item.command == CMD_LOAD_X) &&
                   (r_ext < dim_n) && (c_ext < dim_p);
        wr.lane  = (in_item.command == CMD_LOAD_A) ? in_item.col_index : in_item.row_index;
        wr.entry = (in_item.command == CMD_LOAD_A) ? in_item.row_index : in_item.col_index;
        wr.data  = in_item.element_value;
    end

    // Sequencer: walks (i, j) in row-major order, one token per advancing cycle.
    logic seq_active_reg;
    logic [IDX_W-1:0] i_reg, j_reg;
    logic last_elem;
    tok_t tok_issue;
    logic out_last_taken;

    assign last_elem = ({1'b0, i_reg} == dim_m - DIM_W'(1)) &&
                       ({1'b0, j_reg} == dim_p - DIM_W'(1));

    always_comb
    begin
        tok_issue.valid = seq_active_reg;
        tok_issue.last  = last_elem;
        tok_issue.row   = i_reg;
        tok_issue.col   = j_reg;
    end

    assign out_last_taken = out_valid_reg && !out_stall && out_item_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            seq_active_reg <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
        end
        else
        begin
            if (in_acc && (in_item.command == CMD_COMPUTE))
            begin
                busy_reg       <= 1'b1;
                seq_active_reg <= 1'b1;
                i_reg          <= '0;
                j_reg          <= '0;
            end
            else
            begin
                if (out_last_taken)
                    busy_reg <= 1'b0;
                if (seq_active_reg && advance)
                begin
                    if (last_elem)
                        seq_active_reg <= 1'b0;
                    if ({1'b0, j_reg} == dim_p - DIM_W'(1))
                    begin
                        j_reg <= '0;
                        i_reg <= i_reg + IDX_W'(1);
                    end
                    else
                        j_reg <= j_reg + IDX_W'(1);
                end
            end
        end
    end

    // The cell chain. Each cell adds its term of the dot product to the passing
    // sum; cells at or beyond inner_length add zero.
    tok_t                    tok_chain [MAX_DIM+1];
    logic signed [SUM_W-1:0] sum_chain [MAX_DIM+1];

    assign tok_chain[0] = tok_issue;
    assign sum_chain[0] = '0;

    for (genvar k = 0; k < MAX_DIM; k++)
    begin : g_cell
        mme_cell #(
            .K       (k),
            .MAX_DIM (MAX_DIM)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .inner_n (dim_n),
            .wr      (wr),
            .tok_in  (tok_chain[k]),
            .sum_in  (sum_chain[k]),
            .tok_out (tok_chain[k+1]),
            .sum_out (sum_chain[k+1])
        );
    end

    // Scale back to Q16.16 with floor rounding and clip to 32 bits.
    logic signed [SUM_W-1:0] shifted;
    logic                    neg, fits;
    out_item_t               fin;

    always_comb
    begin
        shifted = sum_chain[MAX_DIM] >>> FRAC_BITS;
        neg     = sum_chain[MAX_DIM][SUM_W-1];
        fits    = (&shifted[SUM_W-1:DATA_W-1]) || !(|shifted[SUM_W-1:DATA_W-1]);
        fin.out_row   = tok_chain[MAX_DIM].row;
        fin.out_col   = tok_chain[MAX_DIM].col;
        fin.last      = tok_chain[MAX_DIM].last;
        fin.saturated = !fits;
        if (fits)
            fin.product_value = shifted[DATA_W-1:0];
        else if (neg)
            fin.product_value = 32'sh8000_0000;
        else
            fin.product_value = 32'sh7FFF_FFFF;
    end

    // Output register: holds a result beat until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= tok_chain[MAX_DIM].valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_item_reg <= fin;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

@@ hw/rtl/mme_cell.sv @@
// One multiply-accumulate cell of the chain: holds column K of A and row K of X.
// Depends on mme_pkg.
module mme_cell
    import mme_pkg::*;
#(
    parameter int K       = 0,
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic [DIM_W-1:0]        inner_n,
    input  wr_t                     wr,
    input  tok_t                    tok_in,
    input  logic signed [SUM_W-1:0] sum_in,
    output tok_t                    tok_out,
    output logic signed [SUM_W-1:0] sum_out
);

    localparam int ENT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    logic [DATA_W-1:0] a_mem_reg [MAX_DIM];
    logic [DATA_W-1:0] x_mem_reg [MAX_DIM];

    tok_t                    tok1_reg, tok2_reg;
    logic                    valid1_reg, valid2_reg;
    logic signed [SUM_W-1:0] sum1_reg, sum2_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [SUM_W-1:0] sum2_next;
    logic                    active;
    logic                    sel;

    assign active = (DIM_W'(K) < inner_n);
    assign sel    = (wr.lane == IDX_W'(K));

    always_comb
    begin
        if (active)
            prod_next = $signed(a_mem_reg[tok_in.row[ENT_W-1:0]]) *
                        $signed(x_mem_reg[tok_in.col[ENT_W-1:0]]);
        else
            prod_next = '0;
        sum2_next = sum1_reg + {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    end

    always_ff @(posedge clk)
    begin
        if (wr.a_we && sel)
            a_mem_reg[wr.entry[ENT_W-1:0]] <= wr.data;
        if (wr.x_we && sel)
            x_mem_reg[wr.entry[ENT_W-1:0]] <= wr.data;
    end

    // Only the valid bits are reset; the rest of the token rides along unreset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid1_reg <= tok_in.valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum1_reg <= sum_in;
            prod_reg <= prod_next;
            sum2_reg <= sum2_next;
            tok1_reg <= tok_in;
            tok2_reg <= tok1_reg;
        end
    end

    always_comb
    begin
        tok_out       = tok2_reg;
        tok_out.valid = valid2_reg;
    end

    assign sum_out = sum2_reg;

endmodule
